[src/pjsd_pkg.sv]
`timescale 1ns / 1ps

package pjsd_pkg;

  localparam int LENGTH_BITS = 32;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    PH_TAG,
    PH_LEN,
    PH_NAME,
    PH_PACKED,
    PH_SKIPB,
    PH_SKIPV,
    PH_IDLE
  } phase_t;

  localparam logic [2:0] KIND_POSITION   = 3'd0;
  localparam logic [2:0] KIND_VELOCITY   = 3'd1;
  localparam logic [2:0] KIND_EFFORT     = 3'd2;
  localparam logic [2:0] KIND_NAME_BYTE  = 3'd3;
  localparam logic [2:0] KIND_EMPTY_NAME = 3'd4;
  localparam logic [2:0] KIND_FINISH     = 3'd5;

  localparam logic [2:0] TGT_POSITION = 3'd0;
  localparam logic [2:0] TGT_NAME     = 3'd3;
  localparam logic [2:0] TGT_SKIP     = 3'd4;

  localparam logic [2:0] WIRE_VARINT  = 3'd0;
  localparam logic [2:0] WIRE_FIXED64 = 3'd1;
  localparam logic [2:0] WIRE_LEN     = 3'd2;
  localparam logic [2:0] WIRE_FIXED32 = 3'd5;

  localparam logic [31:0] FIELD_NAME     = 32'd2;
  localparam logic [31:0] FIELD_POSITION = 32'd3;
  localparam logic [31:0] FIELD_EFFORT   = 32'd5;

  localparam logic [3:0] VARINT_LAST_IDX = 4'd9;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] data_value;
    logic        name_end;
    logic        parse_ok;
    logic        run_last;
  } result_t;

endpackage

[src/pjsd_decode.sv]
`timescale 1ns / 1ps

module pjsd_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        byte_in,
  input  logic              final_byte,
  output logic [1:0]        push_cnt,
  output pjsd_pkg::result_t res0,
  output pjsd_pkg::result_t res1
);

  pjsd_pkg::phase_t                   phase, phase_next;
  logic [63:0]                        varint_acc, varint_acc_next;
  logic [3:0]                         varint_idx, varint_idx_next;
  logic [pjsd_pkg::LENGTH_BITS-1:0]   remaining, remaining_next;
  logic [2:0]                         target, target_next;
  logic [63:0]                        double_acc, double_acc_next;
  logic [2:0]                         double_idx, double_idx_next;
  logic                               seen_name, seen_name_next;
  logic                               seen_position, seen_position_next;
  logic                               error_flag, error_flag_next;

  logic [63:0]                        vacc_new;
  logic                               vdone;
  logic                               vover;
  logic [5:0]                         vshift;
  logic [31:0]                        fnum;
  logic [2:0]                         wtype;
  logic [pjsd_pkg::LENGTH_BITS-1:0]   rem_dec;
  logic [63:0]                        dacc_new;
  logic                               has_data;
  pjsd_pkg::result_t                  data_res;
  pjsd_pkg::result_t                  fin_res;
  logic                               err_fin;

  // shared varint byte step
  always_comb begin
    vshift   = 6'({2'b00, varint_idx} * 6'd7);
    vacc_new = varint_acc | ({57'd0, byte_in[6:0]} << vshift);
    vdone    = !byte_in[7];
    vover    = byte_in[7] && (varint_idx == pjsd_pkg::VARINT_LAST_IDX);
    fnum     = vacc_new[34:3];
    wtype    = vacc_new[2:0];
    rem_dec  = remaining - 1'b1;
    dacc_new = double_acc | ({56'd0, byte_in} << {double_idx, 3'b000});
  end

  always_comb begin
    phase_next         = phase;
    varint_acc_next    = varint_acc;
    varint_idx_next    = varint_idx;
    remaining_next     = remaining;
    target_next        = target;
    double_acc_next    = double_acc;
    double_idx_next    = double_idx;
    seen_name_next     = seen_name;
    seen_position_next = seen_position;
    error_flag_next    = error_flag;

    case (phase)
      pjsd_pkg::PH_TAG, pjsd_pkg::PH_LEN, pjsd_pkg::PH_SKIPV: begin
        varint_acc_next = vacc_new;
        varint_idx_next = varint_idx + 4'd1;
      end
      default: ;
    endcase

    case (phase)
      pjsd_pkg::PH_TAG: begin
        if (vdone) begin
          varint_acc_next = '0;
          varint_idx_next = '0;
          if (fnum == pjsd_pkg::FIELD_NAME && wtype == pjsd_pkg::WIRE_LEN) begin
            target_next = pjsd_pkg::TGT_NAME;
            phase_next  = pjsd_pkg::PH_LEN;
          end else if (fnum >= pjsd_pkg::FIELD_POSITION && fnum <= pjsd_pkg::FIELD_EFFORT
                       && wtype == pjsd_pkg::WIRE_FIXED64) begin
            target_next     = 3'(fnum - pjsd_pkg::FIELD_POSITION);
            remaining_next  = pjsd_pkg::LENGTH_BITS'(8);
            double_acc_next = '0;
            double_idx_next = '0;
            phase_next      = pjsd_pkg::PH_PACKED;
          end else if (fnum >= pjsd_pkg::FIELD_POSITION && fnum <= pjsd_pkg::FIELD_EFFORT
                       && wtype == pjsd_pkg::WIRE_LEN) begin
            target_next = 3'(fnum - pjsd_pkg::FIELD_POSITION);
            phase_next  = pjsd_pkg::PH_LEN;
          end else if (wtype == pjsd_pkg::WIRE_VARINT) begin
            phase_next = pjsd_pkg::PH_SKIPV;
          end else if (wtype == pjsd_pkg::WIRE_FIXED64) begin
            remaining_next = pjsd_pkg::LENGTH_BITS'(8);
            phase_next     = pjsd_pkg::PH_SKIPB;
          end else if (wtype == pjsd_pkg::WIRE_LEN) begin
            target_next = pjsd_pkg::TGT_SKIP;
            phase_next  = pjsd_pkg::PH_LEN;
          end else if (wtype == pjsd_pkg::WIRE_FIXED32) begin
            remaining_next = pjsd_pkg::LENGTH_BITS'(4);
            phase_next     = pjsd_pkg::PH_SKIPB;
          end else begin
            error_flag_next = 1'b1;
            phase_next      = pjsd_pkg::PH_IDLE;
          end
        end else if (vover) begin
          // overlong tag just stops parsing
          phase_next = pjsd_pkg::PH_IDLE;
        end
      end
      pjsd_pkg::PH_LEN: begin
        if (vover) begin
          error_flag_next = 1'b1;
          phase_next      = pjsd_pkg::PH_IDLE;
        end else if (vdone) begin
          if ((vacc_new >> pjsd_pkg::LENGTH_BITS) != 64'd0) begin
            error_flag_next = 1'b1;
            phase_next      = pjsd_pkg::PH_IDLE;
          end else if (vacc_new == 64'd0) begin
            if (target == pjsd_pkg::TGT_NAME) begin
              seen_name_next = 1'b1;
            end
            varint_acc_next = '0;
            varint_idx_next = '0;
            phase_next      = pjsd_pkg::PH_TAG;
          end else begin
            remaining_next  = vacc_new[pjsd_pkg::LENGTH_BITS-1:0];
            double_acc_next = '0;
            double_idx_next = '0;
            if (target == pjsd_pkg::TGT_NAME) begin
              phase_next = pjsd_pkg::PH_NAME;
            end else if (target == pjsd_pkg::TGT_SKIP) begin
              phase_next = pjsd_pkg::PH_SKIPB;
            end else begin
              phase_next = pjsd_pkg::PH_PACKED;
            end
          end
        end
      end
      pjsd_pkg::PH_NAME: begin
        remaining_next = rem_dec;
        if (rem_dec == '0) begin
          seen_name_next  = 1'b1;
          varint_acc_next = '0;
          varint_idx_next = '0;
          phase_next      = pjsd_pkg::PH_TAG;
        end
      end
      pjsd_pkg::PH_PACKED: begin
        remaining_next = rem_dec;
        if (double_idx == 3'd7) begin
          if (target == pjsd_pkg::TGT_POSITION) begin
            seen_position_next = 1'b1;
          end
          double_acc_next = '0;
          double_idx_next = '0;
        end else begin
          double_acc_next = dacc_new;
          double_idx_next = double_idx + 3'd1;
        end
        if (rem_dec == '0) begin
          varint_acc_next = '0;
          varint_idx_next = '0;
          phase_next      = pjsd_pkg::PH_TAG;
        end
      end
      pjsd_pkg::PH_SKIPB: begin
        remaining_next = rem_dec;
        if (rem_dec == '0) begin
          varint_acc_next = '0;
          varint_idx_next = '0;
          phase_next      = pjsd_pkg::PH_TAG;
        end
      end
      pjsd_pkg::PH_SKIPV: begin
        if (vdone) begin
          varint_acc_next = '0;
          varint_idx_next = '0;
          phase_next      = pjsd_pkg::PH_TAG;
        end else if (vover) begin
          error_flag_next = 1'b1;
          phase_next      = pjsd_pkg::PH_IDLE;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    has_data = 1'b0;
    data_res = '0;

    case (phase)
      pjsd_pkg::PH_LEN: begin
        if (vdone && vacc_new == 64'd0 && target == pjsd_pkg::TGT_NAME) begin
          has_data      = 1'b1;
          data_res.kind = pjsd_pkg::KIND_EMPTY_NAME;
        end
      end
      pjsd_pkg::PH_NAME: begin
        has_data            = 1'b1;
        data_res.kind       = pjsd_pkg::KIND_NAME_BYTE;
        data_res.data_value = {56'd0, byte_in};
        data_res.name_end   = (rem_dec == '0);
      end
      pjsd_pkg::PH_PACKED: begin
        if (double_idx == 3'd7) begin
          has_data            = 1'b1;
          data_res.kind       = target;
          data_res.data_value = dacc_new;
        end
      end
      default: ;
    endcase

    // finish beat
    err_fin = error_flag_next || (phase_next != pjsd_pkg::PH_TAG
                                  && phase_next != pjsd_pkg::PH_IDLE);
    fin_res          = '0;
    fin_res.kind     = pjsd_pkg::KIND_FINISH;
    fin_res.parse_ok = !err_fin && (seen_name_next || seen_position_next);
    fin_res.run_last = 1'b1;
    data_res.run_last = !final_byte;

    res0     = has_data ? data_res : fin_res;
    res1     = fin_res;
    push_cnt = accept ? (2'(has_data) + 2'(final_byte)) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && final_byte)) begin
      phase         <= pjsd_pkg::PH_TAG;
      varint_acc    <= '0;
      varint_idx    <= '0;
      remaining     <= '0;
      target        <= '0;
      double_acc    <= '0;
      double_idx    <= '0;
      seen_name     <= 1'b0;
      seen_position <= 1'b0;
      error_flag    <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      varint_acc    <= varint_acc_next;
      varint_idx    <= varint_idx_next;
      remaining     <= remaining_next;
      target        <= target_next;
      double_acc    <= double_acc_next;
      double_idx    <= double_idx_next;
      seen_name     <= seen_name_next;
      seen_position <= seen_position_next;
      error_flag    <= error_flag_next;
    end
  end

endmodule

[src/pjsd_out_queue.sv]
`timescale 1ns / 1ps

module pjsd_out_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        push_cnt,
  input  pjsd_pkg::result_t wdata0,
  input  pjsd_pkg::result_t wdata1,
  output logic              room,
  output logic              result_valid,
  input  logic              result_ready,
  output pjsd_pkg::result_t head
);

  pjsd_pkg::result_t                 entries [pjsd_pkg::QDEPTH];
  logic [pjsd_pkg::QPTR_W-1:0]       wptr, wptr_next;
  logic [pjsd_pkg::QPTR_W-1:0]       rptr, rptr_next;
  logic [pjsd_pkg::QCNT_W-1:0]       count, count_next;
  logic                              pop;
  logic [pjsd_pkg::QPTR_W-1:0]       wptr_plus1;

  always_comb begin
    pop          = result_valid && result_ready;
    wptr_plus1   = wptr + 1'b1;
    wptr_next    = wptr + pjsd_pkg::QPTR_W'(push_cnt);
    rptr_next    = rptr + pjsd_pkg::QPTR_W'(pop);
    count_next   = count + pjsd_pkg::QCNT_W'(push_cnt) - pjsd_pkg::QCNT_W'(pop);
    result_valid = (count != '0);
    // room for a full two-result beat
    room         = (count <= pjsd_pkg::QCNT_W'(pjsd_pkg::QDEPTH - 2));
    head         = entries[rptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr_next;
      rptr  <= rptr_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      entries[wptr] <= wdata0;
    end
    if (push_cnt == 2'd2) begin
      entries[wptr_plus1] <= wdata1;
    end
  end

endmodule

[src/protobuf_joint_state_field_decoder.sv]
`timescale 1ns / 1ps

// Streaming joint-state message decoder. One payload byte is taken per beat on
// byte_valid/byte_ready, and every byte is decoded in the cycle it is taken, so
// the block sustains one byte per clock while byte_ready is high. Results
// (double bit patterns for position, velocity and effort, name bytes,
// empty-name marks and a finish result on the final byte) leave through a
// four-entry result queue, one per clock while result_ready is high; byte_ready
// is low only while that queue has fewer than two free slots, which happens
// when the result side stalls or when final bytes, the only bytes that can give
// two results, come close together. The state returns to reset after every
// final byte, so the next byte starts a new payload.

module protobuf_joint_state_field_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_ready,
  input  logic [7:0]  byte_in,
  input  logic        final_byte,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [2:0]  kind,
  output logic [63:0] data_value,
  output logic        name_end,
  output logic        parse_ok,
  output logic        run_last
);

  logic              accept;
  logic [1:0]        push_cnt;
  pjsd_pkg::result_t res0;
  pjsd_pkg::result_t res1;
  pjsd_pkg::result_t head;
  logic              room;

  assign byte_ready = room;
  assign accept     = byte_valid && room;

  pjsd_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .byte_in    (byte_in),
    .final_byte (final_byte),
    .push_cnt   (push_cnt),
    .res0       (res0),
    .res1       (res1)
  );

  pjsd_out_queue u_queue (
    .clk          (clk),
    .rst          (rst),
    .push_cnt     (push_cnt),
    .wdata0       (res0),
    .wdata1       (res1),
    .room         (room),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .head         (head)
  );

  assign kind       = head.kind;
  assign data_value = head.data_value;
  assign name_end   = head.name_end;
  assign parse_ok   = head.parse_ok;
  assign run_last   = head.run_last;

endmodule
